// ----- src/mpsp_pkg.sv -----
// Shared types, codes and constants of the PUBLISH stream parser.
package mpsp_pkg;

  localparam int TOPIC_DEPTH_DEF   = 64;
  localparam int PAYLOAD_DEPTH_DEF = 256;
  localparam int OUT_DEPTH         = 4;

  localparam logic [1:0] OP_RECEIVE      = 2'd0;
  localparam logic [1:0] OP_READ_TOPIC   = 2'd1;
  localparam logic [1:0] OP_READ_PAYLOAD = 2'd2;
  localparam logic [1:0] OP_CLEAR        = 2'd3;

  localparam logic [2:0] EV_END     = 3'd0;
  localparam logic [2:0] EV_STORED  = 3'd1;
  localparam logic [2:0] EV_TOPIC   = 3'd2;
  localparam logic [2:0] EV_TOOLONG = 3'd3;
  localparam logic [2:0] EV_STOP    = 3'd4;
  localparam logic [2:0] EV_READ    = 3'd5;
  localparam logic [2:0] EV_CLEARED = 3'd6;

  localparam logic [7:0] TYPE_MASK    = 8'hF0;
  localparam logic [7:0] TYPE_PUBLISH = 8'h30;
  localparam logic [7:0] LEN_MASK     = 8'h7F;
  localparam logic [7:0] LEN_CONT     = 8'h80;
  localparam logic [7:0] QOS_MASK     = 8'h06;

  typedef enum logic [7:0] {
    PH_TYPE    = 8'b0000_0001,
    PH_LEN     = 8'b0000_0010,
    PH_TLEN_HI = 8'b0000_0100,
    PH_TLEN_LO = 8'b0000_1000,
    PH_TOPIC   = 8'b0001_0000,
    PH_PKTID   = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_STOPPED = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] read_byte;
    logic [5:0] topic_length;
    logic [7:0] payload_length;
    logic       message_pending;
    logic       buffer_done;
    logic       any_stored;
    logic [7:0] buffer_count;
  } result_t;

endpackage

// ----- src/mpsp_out_fifo.sv -----
// Result queue between the parser pipeline and the output stream.
module mpsp_out_fifo
  import mpsp_pkg::*;
(
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  result_t                            push_res,
  output logic                               out_valid,
  input  logic                               out_ready,
  output result_t                            out_res,
  output logic [$clog2(OUT_DEPTH + 1) - 1:0] count
);

  localparam int AW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  result_t       entries [OUT_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic          pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/mqtt_publish_stream_parser_unit.sv -----
// Top level: PUBLISH stream parser with banked topic and payload stores.
//
//  channel  | dir | tdata                                      | tuser          | tlast
//  s_axis   | in  | data_byte, read_index                      | operation      | end_of_buffer
//  m_axis   | out | read_byte, topic_length, payload_length,   | event_res      | buffer_done
//           |     | message_pending, any_stored, buffer_count  |                |
//
//  One item is taken per cycle while input ready is high; its result is registered in the
//  result stage, in parallel with the registered memory read ports, and then queued.
//  Stores hold two banks each; a packet writes the staging bank and commits by a bank flip.
//  Reset clears the parser state and queue; the memories need no clearing pass.
//  A four-entry result queue absorbs output stalls; input ready falls while reset is high
//  and when the queue and the result stage ahead of it hold four results between them.
module mqtt_publish_stream_parser_unit
  import mpsp_pkg::*;
#(
  parameter int TOPIC_DEPTH   = TOPIC_DEPTH_DEF,
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // data_byte[7:0], read_index[15:8]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_byte[7:0], topic_length[13:8], payload_length[21:14], message_pending[22],
  // any_stored[23], buffer_count[31:24]
  output logic [31:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // event_res[2:0]
  output logic        m_axis_tlast
);

  localparam int TAW = $clog2(TOPIC_DEPTH);
  localparam int TMW = $clog2(2 * TOPIC_DEPTH);
  localparam int PAW = $clog2(PAYLOAD_DEPTH);
  localparam int PMW = $clog2(2 * PAYLOAD_DEPTH);
  localparam int SPW = $clog2(PAYLOAD_DEPTH + 1);
  localparam int CW  = $clog2(OUT_DEPTH + 1);

  logic [7:0] topic_mem   [2 * TOPIC_DEPTH];
  logic [7:0] payload_mem [2 * PAYLOAD_DEPTH];

  phase_t         phase, phase_next;
  logic [27:0]    remaining, remaining_next;
  logic [1:0]     len_count, len_count_next;
  logic [15:0]    topic_len, topic_len_next;
  logic [15:0]    field_pos, field_pos_next;
  logic [SPW-1:0] staged_len, staged_len_next;
  logic [1:0]     qos, qos_next;
  logic           topic_bank, topic_bank_next;
  logic           payload_bank, payload_bank_next;
  logic [TAW-1:0] topic_commit, topic_commit_next;
  logic [PAW-1:0] payload_commit, payload_commit_next;
  logic           pending, pending_next;
  logic           buf_stored, buf_stored_next;
  logic [7:0]     buffers, buffers_next;

  logic           accept;
  logic [1:0]     op;
  logic [7:0]     din;
  logic [7:0]     rd_index;
  logic           ev_valid;
  logic [2:0]     ev;
  logic           done;
  logic           any;
  logic           rd_hit;
  logic           rd_sel_payload;
  logic           tw_en;
  logic           pw_en;
  logic           tr_en;
  logic           pr_en;
  logic [TMW-1:0] tw_addr;
  logic [TMW-1:0] tr_addr;
  logic [PMW-1:0] pw_addr;
  logic [PMW-1:0] pr_addr;
  logic [27:0]    rem_acc;
  logic [27:0]    rem_dec;
  logic [15:0]    tl;
  logic [15:0]    pos_inc;
  logic           check_end;

  logic           p_valid;
  result_t        p_res;
  logic           p_hit;
  logic           p_sel_payload;
  logic [7:0]     topic_q;
  logic [7:0]     payload_q;
  result_t        push_res;
  result_t        out_res;
  logic [CW-1:0]  fifo_count;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign op       = s_axis_tuser;
  assign din      = s_axis_tdata[7:0];
  assign rd_index = s_axis_tdata[15:8];

  assign s_axis_tready = !rst &&
                         (({1'b0, fifo_count} + (CW + 1)'(p_valid)) < (CW + 1)'(OUT_DEPTH));

  always_comb begin
    case (len_count)
      2'd0:    rem_acc = remaining | {21'd0, din[6:0] & LEN_MASK[6:0]};
      2'd1:    rem_acc = remaining | {14'd0, din[6:0] & LEN_MASK[6:0], 7'd0};
      2'd2:    rem_acc = remaining | {7'd0, din[6:0] & LEN_MASK[6:0], 14'd0};
      default: rem_acc = remaining | {din[6:0] & LEN_MASK[6:0], 21'd0};
    endcase
  end

  assign rem_dec = remaining - 28'd1;
  assign tl      = {topic_len[15:8], din};
  assign pos_inc = field_pos + 16'd1;

  assign tw_addr = (topic_bank ? TMW'(0) : TMW'(TOPIC_DEPTH)) + TMW'(field_pos[TAW-1:0]);
  assign pw_addr = (payload_bank ? PMW'(0) : PMW'(PAYLOAD_DEPTH)) + PMW'(staged_len[PAW-1:0]);
  assign tr_addr = (topic_bank ? TMW'(TOPIC_DEPTH) : TMW'(0)) + TMW'(rd_index[TAW-1:0]);
  assign pr_addr = (payload_bank ? PMW'(PAYLOAD_DEPTH) : PMW'(0)) + PMW'(rd_index[PAW-1:0]);

  always_comb begin
    phase_next          = phase;
    remaining_next      = remaining;
    len_count_next      = len_count;
    topic_len_next      = topic_len;
    field_pos_next      = field_pos;
    staged_len_next     = staged_len;
    qos_next            = qos;
    topic_bank_next     = topic_bank;
    payload_bank_next   = payload_bank;
    topic_commit_next   = topic_commit;
    payload_commit_next = payload_commit;
    pending_next        = pending;
    buf_stored_next     = buf_stored;
    buffers_next        = buffers;
    ev_valid            = 1'b0;
    ev                  = EV_END;
    done                = 1'b0;
    any                 = 1'b0;
    rd_hit              = 1'b0;
    rd_sel_payload      = 1'b0;
    tw_en               = 1'b0;
    pw_en               = 1'b0;
    tr_en               = 1'b0;
    pr_en               = 1'b0;
    check_end           = 1'b0;

    if (accept) begin
      case (op)
        OP_RECEIVE: begin
          case (phase)
            PH_TYPE: begin
              if ((din & TYPE_MASK) != TYPE_PUBLISH) begin
                phase_next = PH_STOPPED;
                ev_valid   = 1'b1;
                ev         = EV_STOP;
              end else begin
                qos_next       = 2'((din & QOS_MASK) >> 1);
                remaining_next = '0;
                len_count_next = '0;
                phase_next     = PH_LEN;
              end
            end
            PH_LEN: begin
              remaining_next = rem_acc;
              if (((din & LEN_CONT) != 8'd0) && (len_count != 2'd3)) begin
                len_count_next = len_count + 2'd1;
              end else begin
                len_count_next = '0;
                if (rem_acc < 28'd2) begin
                  phase_next = PH_STOPPED;
                  ev_valid   = 1'b1;
                  ev         = EV_STOP;
                end else begin
                  staged_len_next = '0;
                  topic_len_next  = '0;
                  phase_next      = PH_TLEN_HI;
                end
              end
            end
            PH_TLEN_HI: begin
              remaining_next = rem_dec;
              topic_len_next = {din, 8'd0};
              phase_next     = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
              remaining_next = rem_dec;
              topic_len_next = tl;
              if ({12'd0, tl} > rem_dec) begin
                phase_next = PH_STOPPED;
                ev_valid   = 1'b1;
                ev         = EV_STOP;
              end else begin
                field_pos_next = '0;
                check_end      = 1'b1;
                if (tl != 16'd0) begin
                  phase_next = PH_TOPIC;
                end else begin
                  phase_next = (qos != 2'd0) ? PH_PKTID : PH_PAYLOAD;
                end
              end
            end
            PH_TOPIC: begin
              remaining_next = rem_dec;
              check_end      = 1'b1;
              tw_en          = (field_pos < 16'(TOPIC_DEPTH - 1));
              field_pos_next = pos_inc;
              if (pos_inc >= topic_len) begin
                field_pos_next = '0;
                phase_next     = (qos != 2'd0) ? PH_PKTID : PH_PAYLOAD;
              end
            end
            PH_PKTID: begin
              remaining_next = rem_dec;
              check_end      = 1'b1;
              field_pos_next = pos_inc;
              if (pos_inc >= 16'd2) begin
                phase_next = PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              remaining_next = rem_dec;
              check_end      = 1'b1;
              if (staged_len < SPW'(PAYLOAD_DEPTH)) begin
                pw_en           = 1'b1;
                staged_len_next = staged_len + SPW'(1);
              end
            end
            default: begin
            end
          endcase

          if (check_end && (rem_dec == 28'd0)) begin
            topic_bank_next   = ~topic_bank;
            topic_commit_next = (topic_len_next > 16'(TOPIC_DEPTH - 1)) ?
                                TAW'(TOPIC_DEPTH - 1) : topic_len_next[TAW-1:0];
            phase_next        = PH_TYPE;
            ev_valid          = 1'b1;
            if (staged_len_next == '0) begin
              ev = EV_TOPIC;
            end else if (staged_len_next < SPW'(PAYLOAD_DEPTH)) begin
              payload_bank_next   = ~payload_bank;
              payload_commit_next = staged_len_next[PAW-1:0];
              pending_next        = 1'b1;
              buf_stored_next     = 1'b1;
              ev                  = EV_STORED;
            end else begin
              ev = EV_TOOLONG;
            end
          end

          if (s_axis_tlast) begin
            if (!ev_valid) begin
              ev = EV_END;
            end
            ev_valid        = 1'b1;
            done            = 1'b1;
            any             = buf_stored_next;
            buf_stored_next = 1'b0;
            buffers_next    = buffers + 8'd1;
            phase_next      = PH_TYPE;
            remaining_next  = '0;
            len_count_next  = '0;
            field_pos_next  = '0;
            staged_len_next = '0;
          end
        end
        OP_READ_TOPIC: begin
          ev_valid = 1'b1;
          ev       = EV_READ;
          tr_en    = 1'b1;
          rd_hit   = ({1'b0, rd_index} < 9'(topic_commit));
        end
        OP_READ_PAYLOAD: begin
          ev_valid       = 1'b1;
          ev             = EV_READ;
          pr_en          = 1'b1;
          rd_sel_payload = 1'b1;
          rd_hit         = ({1'b0, rd_index} < 9'(payload_commit));
        end
        default: begin
          ev_valid            = 1'b1;
          ev                  = EV_CLEARED;
          topic_commit_next   = '0;
          payload_commit_next = '0;
          pending_next        = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      topic_mem[tw_addr] <= din;
    end
    if (tr_en) begin
      topic_q <= topic_mem[tr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      payload_mem[pw_addr] <= din;
    end
    if (pr_en) begin
      payload_q <= payload_mem[pr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TYPE;
      remaining      <= '0;
      len_count      <= '0;
      topic_len      <= '0;
      field_pos      <= '0;
      staged_len     <= '0;
      qos            <= '0;
      topic_bank     <= 1'b0;
      payload_bank   <= 1'b0;
      topic_commit   <= '0;
      payload_commit <= '0;
      pending        <= 1'b0;
      buf_stored     <= 1'b0;
      buffers        <= '0;
      p_valid        <= 1'b0;
    end else begin
      phase          <= phase_next;
      remaining      <= remaining_next;
      len_count      <= len_count_next;
      topic_len      <= topic_len_next;
      field_pos      <= field_pos_next;
      staged_len     <= staged_len_next;
      qos            <= qos_next;
      topic_bank     <= topic_bank_next;
      payload_bank   <= payload_bank_next;
      topic_commit   <= topic_commit_next;
      payload_commit <= payload_commit_next;
      pending        <= pending_next;
      buf_stored     <= buf_stored_next;
      buffers        <= buffers_next;
      p_valid        <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_res.ev              <= ev;
    p_res.read_byte       <= 8'd0;
    p_res.topic_length    <= 6'(topic_commit_next);
    p_res.payload_length  <= 8'(payload_commit_next);
    p_res.message_pending <= pending_next;
    p_res.buffer_done     <= done;
    p_res.any_stored      <= any;
    p_res.buffer_count    <= buffers_next;
    p_hit                 <= rd_hit;
    p_sel_payload         <= rd_sel_payload;
  end

  always_comb begin
    push_res = p_res;
    if (p_hit) begin
      push_res.read_byte = p_sel_payload ? payload_q : topic_q;
    end
  end

  mpsp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (p_valid),
    .push_res  (push_res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .count     (fifo_count)
  );

  assign m_axis_tdata = {out_res.buffer_count, out_res.any_stored, out_res.message_pending,
                         out_res.payload_length, out_res.topic_length, out_res.read_byte};
  assign m_axis_tuser = out_res.ev;
  assign m_axis_tlast = out_res.buffer_done;

endmodule

// ----- src/mpsp_checker.sv -----
// Port-level checks of the PUBLISH stream parser, bound to the top level.
module mpsp_checker
  import mpsp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_any_needs_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[23]) |-> m_axis_tlast)
    else $error("any_stored set without buffer_done");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == EV_CLEARED)) |->
    (m_axis_tdata[22:8] == 15'd0) && !m_axis_tlast)
    else $error("clear result shows stored state");

  a_stored_pending: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == EV_STORED)) |->
    m_axis_tdata[22] && (m_axis_tdata[21:14] != 8'd0))
    else $error("stored message without pending flag or length");

  a_read_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != EV_READ)) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("read byte set on a non-read result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind mqtt_publish_stream_parser_unit mpsp_checker u_mpsp_checker (.*);
